// ===== rtl/core/tps_pkg.sv =====
package tps_pkg;

  // Fixed field widths of the item formats.
  localparam int VALUE_BITS = 48;
  localparam int POS_BITS   = 11;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = VALUE_BITS;
  localparam int WIDTH_BITS     = 12;
  localparam int HEIGHT_BITS    = 12;
  localparam int TILE_CFG_BITS  = 7;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_SIZE      = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_THRESHOLD = 2'd3;

  // Register values after reset.
  localparam logic [WIDTH_BITS-1:0]    RST_IMAGE_WIDTH    = 12'd640;
  localparam logic [HEIGHT_BITS-1:0]   RST_IMAGE_HEIGHT   = 12'd480;
  localparam logic [TILE_CFG_BITS-1:0] RST_TILE_SIZE      = 7'd8;
  localparam logic [VALUE_BITS-1:0]    RST_PEAK_THRESHOLD = '0;

  // Default sizing of the top level.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_TILE   = 64;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] response_value;
    logic                         start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]          key_row;
    logic [POS_BITS-1:0]          key_col;
    logic signed [VALUE_BITS-1:0] peak_value;
    logic                         last_of_frame;
  } out_item_t;

endpackage

// ===== rtl/core/tps_ram.sv =====
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address written in the same cycle returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tile_peak_select.sv =====
// Tile peak selector: grid non-maximum suppression over a streamed response image.
//
// Input items carry one corner-response sample each, in raster order, with a
// start-of-frame flag that forces the position back to row 0, column 0. The image
// is cut into square tiles; for every tile that saw a sample above the threshold,
// one output item gives the row and column of the first strictly largest sample,
// the tile maximum and a flag marking the last tile of the frame.
// Both channels use valid and stall. An item is taken every clock cycle when no
// stall is raised. A result passes the read-modify-write stage register and then
// the output queue before it is valid at the output; the tile state lives in one
// memory with a registered read, so each pixel is read at acceptance and written
// back in the next cycle, with the previous write forwarded when both touch the
// same tile column.
// A four-entry output queue parts the channels: input stall is raised only when
// the queue could not take the results still in flight, or while the remainder
// pass runs, so a short output stall costs no input cycles and a long one holds
// the input. Writing the tile size starts a bit-serial remainder pass that
// re-derives the tile position from the counters, one quotient bit per step, with
// the input stalled. Reset restores the register defaults, sets the position to
// row 0, column 0 and empties the queue.
module tile_peak_select #(
  parameter int MAX_WIDTH  = tps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tps_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_TILE   = tps_pkg::DEF_MAX_TILE
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tps_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tps_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_we_i,
  input  logic [tps_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [tps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);

  import tps_pkg::*;

  // Position and size widths follow from the maximum image and tile sizes.
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1) + 1;
  localparam int HW    = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int TS_W  = $clog2(MAX_TILE + 1);
  localparam int CIT_W = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
  localparam int DW    = (CW > RW) ? CW : RW;
  localparam int SW    = (DW > 1) ? $clog2(DW) : 1;
  localparam int VB    = VALUE_BITS;
  localparam int EW    = 1 + CW + RW + VB;
  localparam int QD    = 4;
  localparam int QPW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);

  // Configuration registers.
  logic [WIDTH_BITS-1:0]    image_width_q;
  logic [HEIGHT_BITS-1:0]   image_height_q;
  logic [TILE_CFG_BITS-1:0] tile_size_q;
  logic signed [VB-1:0]     peak_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q    <= RST_IMAGE_WIDTH;
      image_height_q   <= RST_IMAGE_HEIGHT;
      tile_size_q      <= RST_TILE_SIZE;
      peak_threshold_q <= RST_PEAK_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:    image_width_q    <= cfg_wdata_i[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT:   image_height_q   <= cfg_wdata_i[HEIGHT_BITS-1:0];
        REG_TILE_SIZE:      tile_size_q      <= cfg_wdata_i[TILE_CFG_BITS-1:0];
        REG_PEAK_THRESHOLD: peak_threshold_q <= cfg_wdata_i[VB-1:0];
      endcase
    end
  end

  // Sizes as they act: zero behaves as one, anything above the maximum as the maximum.
  logic [31:0]   iw32, ih32, it32;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [TS_W-1:0] ts_eff;

  always_comb begin
    iw32 = 32'(image_width_q);
    ih32 = 32'(image_height_q);
    it32 = 32'(tile_size_q);
    if (iw32 == 32'd0) begin
      w_eff = WW'(1);
    end else if (iw32 > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(iw32);
    end
    if (ih32 == 32'd0) begin
      h_eff = HW'(1);
    end else if (ih32 > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(ih32);
    end
    if (it32 == 32'd0) begin
      ts_eff = TS_W'(1);
    end else if (it32 > 32'(MAX_TILE)) begin
      ts_eff = TS_W'(MAX_TILE);
    end else begin
      ts_eff = TS_W'(it32);
    end
  end

  // Raster position, position inside the tile and the tile column, all kept
  // incrementally so that no division is needed per pixel.
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CIT_W-1:0] cit_q, cit_d;
  logic [CIT_W-1:0] rit_q, rit_d;
  logic [CW-1:0]    tile_q, tile_d;

  // Remainder pass after a tile size write.
  logic                busy_q, busy_d;
  logic [SW-1:0]       step_q, step_d;
  logic [TS_W-1:0]     rem_c_q, rem_c_d, rem_r_q, rem_r_d;
  logic [DW-1:0]       quot_q, quot_d;
  logic [DW-1:0]       col_x, row_x;
  logic [SW-1:0]       bit_idx;
  logic [TS_W:0]       sh_c, sh_r;
  logic                qbit;

  // Acceptance stage.
  logic             in_accept;
  logic [CW-1:0]    a_col;
  logic [RW-1:0]    a_row;
  logic [CIT_W-1:0] a_cit, a_rit;
  logic [CW-1:0]    a_tile;
  logic             a_row_end, a_row_last, a_frame_end, a_col_wrap, a_row_wrap;
  logic             a_tile_end, a_first, a_gt;

  // Read-modify-write stage.
  logic                 s1_valid_q;
  logic [CW-1:0]        s1_addr_q;
  logic signed [VB-1:0] s1_val_q;
  logic [RW-1:0]        s1_row_q;
  logic [CW-1:0]        s1_col_q;
  logic                 s1_first_q, s1_gt_q, s1_tile_end_q, s1_frame_end_q;

  logic [EW-1:0]        rd_data;
  logic                 fw_valid_q;
  logic [CW-1:0]        fw_addr_q;
  logic [EW-1:0]        fw_data_q;
  logic [EW-1:0]        ent, wr_data;
  logic signed [VB-1:0] ent_max, new_max;
  logic [RW-1:0]        ent_row, new_row;
  logic [CW-1:0]        ent_col, new_col;
  logic                 ent_mk, new_mk, upd;

  // Output queue.
  out_item_t          q_mem_q [QD];
  logic [QPW-1:0]     q_head_q, q_tail_q;
  logic [QCW-1:0]     q_count_q;
  logic               push, pop;
  out_item_t          res;

  always_comb begin
    in_accept = in_valid_i && !in_stall_o;

    // Start of frame forces the position to the top-left corner before the sample is used.
    a_col  = in_item_i.start_of_frame ? '0 : col_q;
    a_row  = in_item_i.start_of_frame ? '0 : row_q;
    a_cit  = in_item_i.start_of_frame ? '0 : cit_q;
    a_rit  = in_item_i.start_of_frame ? '0 : rit_q;
    a_tile = in_item_i.start_of_frame ? '0 : tile_q;

    a_row_end   = (WW'(a_col) + WW'(1)) >= w_eff;
    a_row_last  = (HW'(a_row) + HW'(1)) >= h_eff;
    a_frame_end = a_row_end && a_row_last;
    a_col_wrap  = ((TS_W + 1)'(a_cit) + (TS_W + 1)'(1)) >= (TS_W + 1)'(ts_eff);
    a_row_wrap  = ((TS_W + 1)'(a_rit) + (TS_W + 1)'(1)) >= (TS_W + 1)'(ts_eff);
    a_tile_end  = (a_col_wrap || a_row_end) && (a_row_wrap || a_row_last);
    a_first     = (a_cit == '0) && (a_rit == '0);
    a_gt        = in_item_i.response_value > peak_threshold_q;

    // Position of the next pixel.
    if (a_row_end) begin
      col_d  = '0;
      cit_d  = '0;
      tile_d = '0;
      if (a_frame_end) begin
        row_d = '0;
        rit_d = '0;
      end else begin
        row_d = a_row + RW'(1);
        rit_d = a_row_wrap ? '0 : a_rit + CIT_W'(1);
      end
    end else begin
      col_d  = a_col + CW'(1);
      row_d  = a_row;
      rit_d  = a_rit;
      cit_d  = a_col_wrap ? '0 : a_cit + CIT_W'(1);
      tile_d = a_col_wrap ? a_tile + CW'(1) : a_tile;
    end

    // One restoring step per cycle for column and row together; the column
    // quotient is the tile column.
    col_x   = DW'(col_q);
    row_x   = DW'(row_q);
    bit_idx = SW'(DW - 1) - step_q;
    sh_c    = {rem_c_q, col_x[bit_idx]};
    sh_r    = {rem_r_q, row_x[bit_idx]};
    qbit    = sh_c >= (TS_W + 1)'(ts_eff);
    rem_c_d = qbit ? TS_W'(sh_c - (TS_W + 1)'(ts_eff)) : TS_W'(sh_c);
    rem_r_d = (sh_r >= (TS_W + 1)'(ts_eff)) ? TS_W'(sh_r - (TS_W + 1)'(ts_eff))
                                            : TS_W'(sh_r);
    quot_d  = {quot_q[DW-1:0] << 1} | DW'(qbit);
    step_d  = step_q + SW'(1);
    busy_d  = (step_q != SW'(DW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      cit_q   <= '0;
      rit_q   <= '0;
      tile_q  <= '0;
      busy_q  <= 1'b0;
      step_q  <= '0;
      rem_c_q <= '0;
      rem_r_q <= '0;
      quot_q  <= '0;
    end else if (cfg_we_i && (cfg_index_i == REG_TILE_SIZE)) begin
      busy_q  <= 1'b1;
      step_q  <= '0;
      rem_c_q <= '0;
      rem_r_q <= '0;
      quot_q  <= '0;
    end else if (busy_q) begin
      busy_q  <= busy_d;
      step_q  <= step_d;
      rem_c_q <= rem_c_d;
      rem_r_q <= rem_r_d;
      quot_q  <= quot_d;
      if (!busy_d) begin
        cit_q  <= CIT_W'(rem_c_d);
        rit_q  <= CIT_W'(rem_r_d);
        tile_q <= CW'(quot_d);
      end
    end else if (in_accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      cit_q  <= cit_d;
      rit_q  <= rit_d;
      tile_q <= tile_d;
    end
  end

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fw_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      fw_valid_q <= s1_valid_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_addr_q      <= a_tile;
      s1_val_q       <= in_item_i.response_value;
      s1_row_q       <= a_row;
      s1_col_q       <= a_col;
      s1_first_q     <= a_first;
      s1_gt_q        <= a_gt;
      s1_tile_end_q  <= a_tile_end;
      s1_frame_end_q <= a_frame_end;
    end
    if (s1_valid_q) begin
      fw_addr_q <= s1_addr_q;
      fw_data_q <= wr_data;
    end
  end

  tps_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (in_accept),
    .raddr_i (a_tile),
    .rdata_o (rd_data)
  );

  always_comb begin
    // The previous pixel's write-back is newer than what the memory returned.
    ent = (fw_valid_q && (fw_addr_q == s1_addr_q)) ? fw_data_q : rd_data;
    if (s1_first_q) begin
      ent_max = '0;
      ent_row = s1_row_q;
      ent_col = s1_col_q;
      ent_mk  = 1'b0;
    end else begin
      ent_max = ent[VB-1:0];
      ent_row = ent[VB +: RW];
      ent_col = ent[VB + RW +: CW];
      ent_mk  = ent[EW-1];
    end
    upd     = s1_gt_q && (s1_val_q > ent_max);
    new_mk  = ent_mk || s1_gt_q;
    new_max = upd ? s1_val_q : ent_max;
    new_row = upd ? s1_row_q : ent_row;
    new_col = upd ? s1_col_q : ent_col;
    wr_data = {new_mk, new_col, new_row, new_max};

    res.key_row       = POS_BITS'(new_row);
    res.key_col       = POS_BITS'(new_col);
    res.peak_value    = new_max;
    res.last_of_frame = s1_frame_end_q;
    push = s1_valid_q && s1_tile_end_q && new_mk;
    pop  = out_valid_o && !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[q_tail_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_head_q  <= '0;
      q_tail_q  <= '0;
      q_count_q <= '0;
    end else begin
      if (push) begin
        q_tail_q <= q_tail_q + QPW'(1);
      end
      if (pop) begin
        q_head_q <= q_head_q + QPW'(1);
      end
      q_count_q <= q_count_q + QCW'(push) - QCW'(pop);
    end
  end

  assign out_valid_o = (q_count_q != '0);
  assign out_item_o  = q_mem_q[q_head_q];
  // Room is kept for the pixel in the write-back stage and the one about to be accepted.
  assign in_stall_o  = busy_q || ((q_count_q + QCW'(s1_valid_q)) > QCW'(QD - 1));

  // The queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((q_count_q < QCW'(QD)) || pop))
    else $error("output queue overflow");

  // No pixel is taken while the tile position is being re-derived.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_accept)
    else $error("pixel accepted during remainder pass");

  // A tile size write starts the remainder pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_index_i == REG_TILE_SIZE)) |=> busy_q)
    else $error("tile size write did not start remainder pass");

  // Outside the remainder pass the in-tile position lies inside the tile.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (((TS_W + 1)'(cit_q) < (TS_W + 1)'(ts_eff)) &&
                 ((TS_W + 1)'(rit_q) < (TS_W + 1)'(ts_eff))))
    else $error("in-tile position outside tile");

endmodule
